### design/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants for the stereo voice mixer
// Holds the frame and result item layouts, the per-voice coefficient
// record and the fixed widths of the mix datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int LAYOUT_VOICES  = 4;
    localparam int NUM_VOICES_DEF = 4;

    localparam int SAMPLE_W    = 16;
    localparam int ATTEN_W     = 13;
    localparam int PAN_W       = 14;
    localparam int COEF_W      = 13;
    localparam int PROD1_W     = 29;
    localparam int TERM_W      = 42;
    localparam int SUM_W       = 44;
    localparam int MIX_SHIFT   = 24;
    localparam int OUT_W       = 16;
    localparam int SCALED_W    = SUM_W - MIX_SHIFT;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int VOICE_IDX_W = 2;

    localparam int Q12_ONE   = 4096;
    localparam int PAN_RESET = 2048;
    localparam int OUT_MAX   = 32767;
    localparam int OUT_MIN   = -32768;

    localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << MIX_SHIFT) - 1);

    // Low bit of the register index selects the register kind of a voice
    localparam logic REG_KIND_ATTEN = 1'b0;
    localparam logic REG_KIND_PAN   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COEF_W-1:0]          coef_t;
    typedef logic signed [TERM_W-1:0]   term_t;

    typedef struct packed {
        coef_t gain;
        coef_t pan_left;
        coef_t pan_right;
    } voice_coef_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] voice0_left;
        logic signed [SAMPLE_W-1:0] voice0_right;
        logic signed [SAMPLE_W-1:0] voice1_left;
        logic signed [SAMPLE_W-1:0] voice1_right;
        logic signed [SAMPLE_W-1:0] voice2_left;
        logic signed [SAMPLE_W-1:0] voice2_right;
        logic signed [SAMPLE_W-1:0] voice3_left;
        logic signed [SAMPLE_W-1:0] voice3_right;
        logic [LAYOUT_VOICES-1:0]   active_mask;
        logic                       last_in_block;
    } mix_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
        logic                    last_out;
    } mix_out_t;

endpackage

### design/svm_lane.sv
// ----------------------------------------------------------------------------
// svm_lane: two-stage gain and pan multiply for one voice
// Stage one scales both samples by the voice gain, stage two by the pan
// factor of each channel. An inactive voice yields zero terms.
// ----------------------------------------------------------------------------
module svm_lane
    import svm_pkg::*;
(
    input  logic        clk,
    input  sample_t     sample_left,
    input  sample_t     sample_right,
    input  logic        active,
    input  voice_coef_t coef,
    output term_t       term_left,
    output term_t       term_right
);

    logic signed [PROD1_W-1:0] prod_left_reg;
    logic signed [PROD1_W-1:0] prod_right_reg;
    logic signed [PROD1_W-1:0] prod_left_next;
    logic signed [PROD1_W-1:0] prod_right_next;
    logic signed [PROD1_W:0]   samp_left_ext;
    logic signed [PROD1_W:0]   samp_right_ext;
    logic signed [PROD1_W:0]   gain_ext;
    logic signed [PROD1_W:0]   full_left1;
    logic signed [PROD1_W:0]   full_right1;
    term_t                     term_left_reg;
    term_t                     term_right_reg;
    term_t                     term_left_next;
    term_t                     term_right_next;
    term_t                     prod_left_ext;
    term_t                     prod_right_ext;
    term_t                     pan_left_ext;
    term_t                     pan_right_ext;

    // Stage one: sample times gain, zero when the voice is idle
    always_comb
    begin
        samp_left_ext   = (PROD1_W + 1)'(sample_left);
        samp_right_ext  = (PROD1_W + 1)'(sample_right);
        gain_ext        = $signed({{(PROD1_W + 1 - COEF_W){1'b0}}, coef.gain});
        full_left1      = samp_left_ext * gain_ext;
        full_right1     = samp_right_ext * gain_ext;
        prod_left_next  = active ? full_left1[PROD1_W-1:0] : '0;
        prod_right_next = active ? full_right1[PROD1_W-1:0] : '0;
    end

    // Stage two: apply the pan factor of each channel
    always_comb
    begin
        prod_left_ext   = TERM_W'(prod_left_reg);
        prod_right_ext  = TERM_W'(prod_right_reg);
        pan_left_ext    = $signed({{(TERM_W - COEF_W){1'b0}}, coef.pan_left});
        pan_right_ext   = $signed({{(TERM_W - COEF_W){1'b0}}, coef.pan_right});
        term_left_next  = prod_left_ext * pan_left_ext;
        term_right_next = prod_right_ext * pan_right_ext;
    end

    always_ff @(posedge clk)
    begin
        prod_left_reg  <= prod_left_next;
        prod_right_reg <= prod_right_next;
        term_left_reg  <= term_left_next;
        term_right_reg <= term_right_next;
    end

    assign term_left  = term_left_reg;
    assign term_right = term_right_reg;

endmodule

### design/stereo_voice_mixer.sv
// ----------------------------------------------------------------------------
// stereo_voice_mixer: four-voice stereo mixer with attenuation and pan
// Throughput: one frame per cycle; busy stays low, the receiver cannot stall.
// Depth is set by the pipeline: gain multiply, pan multiply, voice sum,
// scale and saturate. Reset clears all valid bits and loads the register
// defaults (attenuation 0, pan 2048); no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_voice_mixer
    import svm_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // frame in
    input  logic                   start,
    output logic                   busy,
    input  mix_in_t                frame,
    // mixed item out
    output logic                   done,
    output mix_out_t               result
);

    // ------------------------------------------------------------------
    // Configuration: each write is clamped and turned straight into the
    // coefficients the datapath uses, so no subtract sits in front of the
    // first multiplier.
    //   gain      = 4096 - atten
    //   pan_left  = min(4096 - pan, 4096)
    //   pan_right = min(4096 + pan, 4096)
    // ------------------------------------------------------------------
    voice_coef_t                 coef_reg [NUM_VOICES];
    voice_coef_t                 coef_next;
    logic [ATTEN_W-1:0]          atten_raw;
    logic [ATTEN_W-1:0]          atten_sat;
    logic signed [PAN_W-1:0]     pan_raw;
    logic signed [PAN_W-1:0]     pan_sat;
    logic signed [PAN_W:0]       pan_left_wide;
    logic signed [PAN_W:0]       pan_right_wide;
    logic [VOICE_IDX_W-1:0]      cfg_voice;
    logic                        cfg_kind;

    assign cfg_voice = cfg_index[CFG_INDEX_W-1:1];
    assign cfg_kind  = cfg_index[0];

    always_comb
    begin
        atten_raw = cfg_data[ATTEN_W-1:0];
        atten_sat = (atten_raw > ATTEN_W'(Q12_ONE)) ? ATTEN_W'(Q12_ONE) : atten_raw;

        pan_raw = $signed(cfg_data[PAN_W-1:0]);
        if (pan_raw < PAN_W'(-Q12_ONE))
        begin
            pan_sat = PAN_W'(-Q12_ONE);
        end
        else if (pan_raw > PAN_W'(Q12_ONE))
        begin
            pan_sat = PAN_W'(Q12_ONE);
        end
        else
        begin
            pan_sat = pan_raw;
        end

        pan_left_wide  = (PAN_W + 1)'(Q12_ONE) - (PAN_W + 1)'(pan_sat);
        pan_right_wide = (PAN_W + 1)'(Q12_ONE) + (PAN_W + 1)'(pan_sat);

        coef_next.gain      = COEF_W'(Q12_ONE) - atten_sat;
        coef_next.pan_left  = (pan_sat < 0) ? COEF_W'(Q12_ONE) : pan_left_wide[COEF_W-1:0];
        coef_next.pan_right = (pan_sat > 0) ? COEF_W'(Q12_ONE) : pan_right_wide[COEF_W-1:0];
    end

    // Writes to voices past NUM_VOICES match no entry and drop out here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                coef_reg[v].gain      <= COEF_W'(Q12_ONE);
                coef_reg[v].pan_left  <= COEF_W'(Q12_ONE - PAN_RESET);
                coef_reg[v].pan_right <= COEF_W'(Q12_ONE);
            end
        end
        else if (cfg_write)
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                if (cfg_voice == VOICE_IDX_W'(v))
                begin
                    unique case (cfg_kind)
                        REG_KIND_ATTEN: coef_reg[v].gain <= coef_next.gain;
                        REG_KIND_PAN:
                        begin
                            coef_reg[v].pan_left  <= coef_next.pan_left;
                            coef_reg[v].pan_right <= coef_next.pan_right;
                        end
                        default: coef_reg[v] <= coef_reg[v];
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the pipeline never stalls, so a frame is taken on every
    // cycle that start is high.
    // ------------------------------------------------------------------
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Unpack the frame into per-voice lanes
    sample_t left_in  [LAYOUT_VOICES];
    sample_t right_in [LAYOUT_VOICES];

    assign left_in[0]  = frame.voice0_left;
    assign right_in[0] = frame.voice0_right;
    assign left_in[1]  = frame.voice1_left;
    assign right_in[1] = frame.voice1_right;
    assign left_in[2]  = frame.voice2_left;
    assign right_in[2] = frame.voice2_right;
    assign left_in[3]  = frame.voice3_left;
    assign right_in[3] = frame.voice3_right;

    // Stages one and two: per-voice multiplies
    term_t term_left  [NUM_VOICES];
    term_t term_right [NUM_VOICES];

    for (genvar v = 0; v < NUM_VOICES; v++)
    begin : g_lane
        svm_lane u_lane
        (
            .clk          (clk),
            .sample_left  (left_in[v]),
            .sample_right (right_in[v]),
            .active       (frame.active_mask[v]),
            .coef         (coef_reg[v]),
            .term_left    (term_left[v]),
            .term_right   (term_right[v])
        );
    end

    // ------------------------------------------------------------------
    // Valid bits and the block marker travel alongside the data
    // ------------------------------------------------------------------
    logic valid1_reg;
    logic valid2_reg;
    logic valid3_reg;
    logic done_reg;
    logic last1_reg;
    logic last2_reg;
    logic last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            done_reg   <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        last1_reg <= frame.last_in_block;
        last2_reg <= last1_reg;
        last3_reg <= last2_reg;
    end

    // ------------------------------------------------------------------
    // Stage three: exact sum of the voice terms, 44 bits never overflow
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_left_reg;
    logic signed [SUM_W-1:0] sum_right_reg;
    logic signed [SUM_W-1:0] sum_left_next;
    logic signed [SUM_W-1:0] sum_right_next;

    always_comb
    begin
        sum_left_next  = '0;
        sum_right_next = '0;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            sum_left_next  = sum_left_next + SUM_W'(term_left[v]);
            sum_right_next = sum_right_next + SUM_W'(term_right[v]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_left_reg  <= sum_left_next;
        sum_right_reg <= sum_right_next;
    end

    // ------------------------------------------------------------------
    // Stage four: divide by 2^24 toward zero (bias negatives before the
    // shift), then clamp to the int16 range.
    // ------------------------------------------------------------------
    function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0]           adj;
        logic signed [SCALED_W-1:0] q;
        logic signed [OUT_W-1:0]    r;
        adj = s + (s[SUM_W-1] ? TRUNC_BIAS : SUM_W'(0));
        q   = $signed(adj[SUM_W-1:MIX_SHIFT]);
        if (q > SCALED_W'(OUT_MAX))
        begin
            r = OUT_W'(OUT_MAX);
        end
        else if (q < SCALED_W'(OUT_MIN))
        begin
            r = OUT_W'(OUT_MIN);
        end
        else
        begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

    mix_out_t result_reg;
    mix_out_t result_next;

    always_comb
    begin
        result_next.left_out  = scale_sat(sum_left_reg);
        result_next.right_out = scale_sat(sum_right_reg);
        result_next.last_out  = last3_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/svm_checker.sv
// ----------------------------------------------------------------------------
// svm_checker: port-level checks for the stereo voice mixer
// Watches the frame and result ports and checks timing of results, the
// block marker and the silent mix.
// ----------------------------------------------------------------------------
module svm_checker
    import svm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  mix_in_t  frame,
    input  logic     done,
    input  mix_out_t result
);

    // The mixer never holds off a frame
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("svm: busy raised");

    // Every taken frame yields exactly one item, and no item comes without a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy && rst_n, 4))
        else $error("svm: result strobe does not match frame timing");

    // Block marker rides with its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.last_out == $past(frame.last_in_block, 4))
        else $error("svm: last_out lost its frame");

    // No active voice gives silence on both channels
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(frame.active_mask == '0, 4))
            |-> (result.left_out == '0 && result.right_out == '0))
        else $error("svm: silent frame produced output");

endmodule

bind stereo_voice_mixer svm_checker u_svm_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .frame  (frame),
    .done   (done),
    .result (result)
);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for stereo_voice_mixer
// Drives stereo frames through the mixer with random sender gaps and checks
// every mixed item against an in-bench predictor of the attenuation, pan,
// full-precision voice sum, truncating scale and int16 saturation. Register
// settings change only while the pipeline is drained.
// ----------------------------------------------------------------------------
module testbench
    import svm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Frame-to-result latency, plus a little slack after draining
    localparam int MIX_LATENCY    = 4;
    localparam int SETTLE_CYCLES  = MIX_LATENCY + 2;
    localparam int MAX_GAP        = 13;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_FRAMES   = 185;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    logic                   busy;
    mix_in_t                frame;
    logic                   done;
    mix_out_t               result;

    // Shadow of the mixer's register settings, as clamped attenuation and pan values
    int       atten_q12 [LAYOUT_VOICES];
    int       pan_q12   [LAYOUT_VOICES];

    // Mixed items still owed by the mixer, oldest first
    mix_out_t pending_mix [$];

    int       mismatch_count;
    int       idle_cycles;
    bit       burst;

    stereo_voice_mixer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .frame     (frame),
        .done      (done),
        .result    (result)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Scale by 2^-24 with truncation toward zero, then clamp to int16
    function automatic logic signed [OUT_W-1:0] scale_to_s16(input longint sum);
        longint q;
        begin
            q = sum / (longint'(1) << MIX_SHIFT);
            if (q > OUT_MAX)
                q = OUT_MAX;
            if (q < OUT_MIN)
                q = OUT_MIN;
            return OUT_W'(q);
        end
    endfunction

    // Mix one frame with the current register shadow
    function automatic mix_out_t mix_frame(input mix_in_t f);
        sample_t  left_s  [LAYOUT_VOICES];
        sample_t  right_s [LAYOUT_VOICES];
        longint   sum_l;
        longint   sum_r;
        longint   gain;
        longint   coef_l;
        longint   coef_r;
        mix_out_t r;
        begin
            left_s  = '{f.voice0_left,  f.voice1_left,  f.voice2_left,  f.voice3_left};
            right_s = '{f.voice0_right, f.voice1_right, f.voice2_right, f.voice3_right};
            sum_l = 0;
            sum_r = 0;
            for (int v = 0; v < LAYOUT_VOICES; v++)
            begin
                if (f.active_mask[v])
                begin
                    gain   = Q12_ONE - atten_q12[v];
                    // pan only ever cuts a side, it never boosts past unity
                    coef_l = (Q12_ONE - pan_q12[v] < Q12_ONE) ? Q12_ONE - pan_q12[v]
                                                               : Q12_ONE;
                    coef_r = (Q12_ONE + pan_q12[v] < Q12_ONE) ? Q12_ONE + pan_q12[v]
                                                               : Q12_ONE;
                    sum_l += longint'(left_s[v])  * gain * coef_l;
                    sum_r += longint'(right_s[v]) * gain * coef_r;
                end
            end
            r.left_out  = scale_to_s16(sum_l);
            r.right_out = scale_to_s16(sum_r);
            r.last_out  = f.last_in_block;
            return r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what,
                     got, want);
            mismatch_count++;
        end
    endtask

    // Each strobed item is compared with the oldest prediction. Outputs are
    // sampled at the edge, before the mixer's own updates land.
    always @(posedge clk)
    begin
        mix_out_t want;
        if (rst_n && done)
        begin
            if (pending_mix.size() == 0)
            begin
                report_mismatch("frames outstanding", 0, 1);
            end
            else
            begin
                want = pending_mix.pop_front();
                if (result.left_out !== want.left_out)
                    report_mismatch("left_out", result.left_out, want.left_out);
                if (result.right_out !== want.right_out)
                    report_mismatch("right_out", result.right_out, want.right_out);
                if (result.last_out !== want.last_out)
                    report_mismatch("last_out", result.last_out, want.last_out);
            end
        end
    end

    // Count cycles in which nothing moves on any port; a hang ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", idle_cycles);
            $display("stereo_voice_mixer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Hand one frame to the mixer. Start is left high on return so that a
    // back-to-back frame does not drop and raise it in the same step.
    task automatic send_frame(input mix_in_t f);
        int gap;
        begin
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            frame <= f;
            do
                @(posedge clk);
            while (busy);
            pending_mix.push_back(mix_frame(f));
        end
    endtask

    // Drop start and hold until every owed item is back, plus the latency
    task automatic drain_mixer();
        begin
            start <= 1'b0;
            while (pending_mix.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // Write all eight registers back to back with raw data; only call with
    // the pipeline drained. The shadow follows the mixer's clamping rules.
    task automatic program_mix(input logic [CFG_DATA_W-1:0] atten_raw [LAYOUT_VOICES],
                               input logic [CFG_DATA_W-1:0] pan_raw   [LAYOUT_VOICES]);
        int p;
        begin
            for (int v = 0; v < LAYOUT_VOICES; v++)
            begin
                cfg_write <= 1'b1;
                cfg_index <= {VOICE_IDX_W'(v), REG_KIND_ATTEN};
                cfg_data  <= atten_raw[v];
                @(posedge clk);
                // atten keeps only 13 bits and clamps at mute
                atten_q12[v] = (atten_raw[v][ATTEN_W-1:0] > Q12_ONE) ? Q12_ONE
                                                                     : atten_raw[v][ATTEN_W-1:0];
                cfg_index <= {VOICE_IDX_W'(v), REG_KIND_PAN};
                cfg_data  <= pan_raw[v];
                @(posedge clk);
                p = int'($signed(pan_raw[v]));
                if (p < -Q12_ONE)
                    p = -Q12_ONE;
                if (p > Q12_ONE)
                    p = Q12_ONE;
                pan_q12[v] = p;
            end
            cfg_write <= 1'b0;
        end
    endtask

    // Same samples on every voice; the mask picks which voices play
    function automatic mix_in_t uniform_frame(input sample_t l, input sample_t r,
                                              input logic [3:0] mask, input logic last);
        mix_in_t f;
        begin
            f = '{l, r, l, r, l, r, l, r, mask, last};
            return f;
        end
    endfunction

    // Samples lean on the rails and on zero crossings
    function automatic sample_t pick_sample();
        begin
            case ($urandom_range(0, 7))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return '0;
                3:       return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
                default: return SAMPLE_W'($urandom);
            endcase
        end
    endfunction

    function automatic mix_in_t random_frame();
        mix_in_t f;
        begin
            f.voice0_left   = pick_sample();
            f.voice0_right  = pick_sample();
            f.voice1_left   = pick_sample();
            f.voice1_right  = pick_sample();
            f.voice2_left   = pick_sample();
            f.voice2_right  = pick_sample();
            f.voice3_left   = pick_sample();
            f.voice3_right  = pick_sample();
            f.active_mask   = LAYOUT_VOICES'($urandom_range(0, 15));
            f.last_in_block = 1'($urandom_range(0, 1));
            return f;
        end
    endfunction

    // Raw write data: in-range values, the limits, and anything 14 bits hold
    function automatic logic [CFG_DATA_W-1:0] pick_atten_raw();
        begin
            case ($urandom_range(0, 5))
                0:       return CFG_DATA_W'(0);
                1:       return CFG_DATA_W'(Q12_ONE);
                2:       return CFG_DATA_W'($urandom);
                default: return CFG_DATA_W'($urandom_range(0, Q12_ONE));
            endcase
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pan_raw();
        begin
            case ($urandom_range(0, 6))
                0:       return CFG_DATA_W'(-Q12_ONE);
                1:       return CFG_DATA_W'(Q12_ONE);
                2:       return CFG_DATA_W'(0);
                3:       return CFG_DATA_W'($urandom);
                default: return CFG_DATA_W'(int'($urandom_range(0, 2 * Q12_ONE)) - Q12_ONE);
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Register defaults after reset: full level, pan half right
    task automatic test_reset_defaults();
        begin
            send_frame(uniform_frame(16'sh7FFF, 16'sh7FFF, 4'b0001, 1'b0));
            send_frame(uniform_frame(16'sh8000, 16'sh8000, 4'b1111, 1'b1));
            send_frame(uniform_frame(16'sh1234, 16'shEDCB, 4'b1000, 1'b0));
        end
    endtask

    // Rails, the all-silent mask, and sums that must saturate
    task automatic test_sample_extremes();
        begin
            drain_mixer();
            program_mix('{14'd0, 14'd0, 14'd0, 14'd0}, '{14'd0, 14'd0, 14'd0, 14'd0});
            send_frame(uniform_frame(16'sh7FFF, 16'sh8000, 4'b0001, 1'b1));
            send_frame(uniform_frame(16'sh8000, 16'sh7FFF, 4'b1000, 1'b0));
            send_frame(uniform_frame(16'sh7FFF, 16'sh7FFF, 4'b1111, 1'b1));
            send_frame(uniform_frame(16'sh8000, 16'sh8000, 4'b1111, 1'b0));
            // no voice playing: silence even with loud samples
            send_frame(uniform_frame(16'sh7FFF, 16'sh8000, 4'b0000, 1'b1));
            send_frame(uniform_frame(16'sh4000, 16'shC000, 4'b0110, 1'b0));
        end
    endtask

    // Gain of one LSB: tiny negative sums must round to zero, not to -1
    task automatic test_truncation();
        begin
            drain_mixer();
            program_mix('{14'd4095, 14'd4095, 14'd4095, 14'd4095},
                        '{14'd0, 14'd0, 14'd0, 14'd0});
            send_frame(uniform_frame(-16'sd4095, 16'sd4095, 4'b0001, 1'b0));
            send_frame(uniform_frame(-16'sd4097, -16'sd1, 4'b0011, 1'b1));
            send_frame(uniform_frame(16'sh8000, 16'sh7FFF, 4'b1111, 1'b0));
        end
    endtask

    // Out-of-range writes clamp: atten past mute, pan past either side
    task automatic test_register_clamp();
        begin
            drain_mixer();
            // 8191 and 4097 clamp to mute; 0x3000 keeps 13 bits (mute); 0x2001 is 1
            program_mix('{14'd8191, 14'h3000, 14'h2001, 14'd4097},
                        '{14'h2000, 14'h1FFF, 14'h3FFF, 14'd4097});
            send_frame(uniform_frame(16'sh7FFF, 16'sh7FFF, 4'b1111, 1'b1));
            send_frame(uniform_frame(16'sh8000, 16'sh7FFF, 4'b0100, 1'b0));
            send_frame(uniform_frame(16'sh7FFF, 16'sh8000, 4'b0001, 1'b1));
        end
    endtask

    // Hard left and hard right at full level
    task automatic test_full_pan();
        begin
            drain_mixer();
            program_mix('{14'd0, 14'd0, 14'd0, 14'd0},
                        '{14'h3000, 14'd4096, 14'h3000, 14'd4096});
            send_frame(uniform_frame(16'sh7FFF, 16'sh7FFF, 4'b0101, 1'b0));
            send_frame(uniform_frame(16'sh8000, 16'sh8000, 4'b1010, 1'b1));
            send_frame(uniform_frame(16'sh2000, 16'shE000, 4'b1111, 1'b0));
        end
    endtask

    // Phases of random frames, each with a fresh random register setting.
    // Gaps come and go in stretches; one phase stops midway until drained.
    task automatic test_random_mix();
        logic [CFG_DATA_W-1:0] atten_raw [LAYOUT_VOICES];
        logic [CFG_DATA_W-1:0] pan_raw   [LAYOUT_VOICES];
        begin
            for (int phase = 0; phase < RANDOM_PHASES; phase++)
            begin
                drain_mixer();
                for (int v = 0; v < LAYOUT_VOICES; v++)
                begin
                    atten_raw[v] = pick_atten_raw();
                    pan_raw[v]   = pick_pan_raw();
                end
                program_mix(atten_raw, pan_raw);
                burst = (phase % 3 == 1);
                for (int i = 0; i < PHASE_FRAMES; i++)
                begin
                    if (phase == RANDOM_PHASES / 2 && i == PHASE_FRAMES / 2)
                        drain_mixer();
                    if ($urandom_range(0, 24) == 0)
                        burst = !burst;
                    send_frame(random_frame());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        start          = 1'b0;
        frame          = '0;
        burst          = 1'b0;
        for (int v = 0; v < LAYOUT_VOICES; v++)
        begin
            atten_q12[v] = 0;
            pan_q12[v]   = PAN_RESET;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_sample_extremes();
        test_truncation();
        test_register_clamp();
        test_full_pan();
        test_random_mix();

        // Let the pipeline empty; the watchdog bounds this wait
        drain_mixer();

        if (mismatch_count == 0)
            $display("stereo_voice_mixer regression: pass");
        else
            $display("stereo_voice_mixer regression: fail");
        $finish;
    end

endmodule

### sim.f
design/svm_pkg.sv
design/svm_lane.sv
design/stereo_voice_mixer.sv
design/svm_checker.sv
verif/testbench.sv
